// ===== sv/ntwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwe_pkg
// Shared types and constants of the neighbor table.
// ----------------------------------------------------------------------------
package ntwe_pkg;

	localparam int unsigned RATE_WINDOW_MS = 1000;
	localparam int unsigned ENTRY_W        = 168; // hash high, hash low, hops, last seen

	localparam logic [2:0] MODE_ANNOUNCE      = 3'd0;
	localparam logic [2:0] MODE_ADD_CONTACT   = 3'd1;
	localparam logic [2:0] MODE_LOOKUP        = 3'd2;
	localparam logic [2:0] MODE_COUNT_ONLINE  = 3'd3;
	localparam logic [2:0] MODE_CLEAR_UNSAVED = 3'd4;
	localparam logic [2:0] MODE_CLEAR_ALL     = 3'd5;

	localparam logic [3:0] ST_INSERTED     = 4'd0;
	localparam logic [3:0] ST_UPDATED      = 4'd1;
	localparam logic [3:0] ST_OWN          = 4'd2;
	localparam logic [3:0] ST_RATE_LIMITED = 4'd3;
	localparam logic [3:0] ST_TOO_SOON     = 4'd4;
	localparam logic [3:0] ST_DROPPED_FULL = 4'd5;
	localparam logic [3:0] ST_FOUND        = 4'd6;
	localparam logic [3:0] ST_NOT_FOUND    = 4'd7;
	localparam logic [3:0] ST_DONE         = 4'd8;

	localparam logic [2:0] REG_STALE_AGE    = 3'd0;
	localparam logic [2:0] REG_MIN_INTERVAL = 3'd1;
	localparam logic [2:0] REG_RATE_LIMIT   = 3'd2;
	localparam logic [2:0] REG_OWN_HIGH     = 3'd3;
	localparam logic [2:0] REG_OWN_LOW      = 3'd4;
	localparam logic [2:0] REG_OWN_ENABLE   = 3'd5;

	typedef enum logic [1:0] {
		KIND_RUN,
		KIND_OWN,
		KIND_RATE
	} kind_t;

	typedef struct packed {
		logic [31:0] stale_age;
		logic [31:0] min_interval;
		logic [7:0]  rate_limit;
		logic [63:0] own_high;
		logic [63:0] own_low;
		logic        own_enable;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  mode;
		logic [63:0] hash_high;
		logic [63:0] hash_low;
		logic [7:0]  hops;
		logic [31:0] now;
		logic [31:0] max_age;
	} item_t;

	typedef struct packed {
		logic        save_pending;
		logic [6:0]  online_count;
		logic        entry_is_saved;
		logic [31:0] entry_last_seen;
		logic [7:0]  entry_hops;
		logic [5:0]  slot;
		logic [3:0]  status;
	} result_t;

endpackage

// ===== sv/ntwe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwe_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ntwe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/ntwe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwe_front
// Input side: own-hash filter and per-second announce rate limit.
// ----------------------------------------------------------------------------
module ntwe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ntwe_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	input  logic [207:0]         in_data,
	input  logic                 full,
	output logic                 in_ready,
	output logic                 push,
	output ntwe_pkg::item_t      item
);

	logic [31:0] win_start_q;
	logic [7:0]  rate_cnt_q;
	logic [31:0] win_diff;
	logic [7:0]  cnt_base;
	logic [7:0]  cnt_next;
	logic        is_announce;
	logic        is_own;

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		item.mode      = in_data[2:0];
		item.hash_high = in_data[66:3];
		item.hash_low  = in_data[130:67];
		item.hops      = in_data[138:131];
		item.now       = in_data[170:139];
		item.max_age   = in_data[202:171];
		is_announce    = (item.mode == ntwe_pkg::MODE_ANNOUNCE);
		is_own         = cfg.own_enable && (item.hash_high == cfg.own_high)
			&& (item.hash_low == cfg.own_low);
		win_diff       = item.now - win_start_q;
		cnt_base       = (win_diff >= 32'(ntwe_pkg::RATE_WINDOW_MS)) ? 8'd0 : rate_cnt_q;
		cnt_next       = (cnt_base == 8'hFF) ? cnt_base : cnt_base + 8'd1;
		if (!is_announce) begin
			item.kind = ntwe_pkg::KIND_RUN;
		end else if (is_own) begin
			item.kind = ntwe_pkg::KIND_OWN;
		end else if (cnt_next > cfg.rate_limit) begin
			item.kind = ntwe_pkg::KIND_RATE;
		end else begin
			item.kind = ntwe_pkg::KIND_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			rate_cnt_q  <= '0;
		end else if (push && is_announce && !is_own) begin
			if (win_diff >= 32'(ntwe_pkg::RATE_WINDOW_MS)) begin
				win_start_q <= item.now;
			end
			rate_cnt_q <= cnt_next;
		end
	end

endmodule

// ===== sv/ntwe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwe_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ntwe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ntwe_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output ntwe_pkg::item_t head
);

	ntwe_pkg::item_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/ntwe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntwe_back
// Table side: slot-per-cycle scan, refresh, insert, purge and eviction.
// ----------------------------------------------------------------------------
module ntwe_back #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ntwe_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	input  ntwe_pkg::item_t      q_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ntwe_pkg::result_t    out_res
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_INSERT,
		S_OUT
	} state_t;

	state_t              state_q;
	ntwe_pkg::item_t     it_q;
	ntwe_pkg::result_t   res_q;
	ntwe_pkg::result_t   res_init;
	ntwe_pkg::result_t   out_q;
	logic                out_valid_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] saved_q;
	logic [TABLE_DEPTH-1:0] stale_q;
	logic                dirty_q;
	logic [CNT_W-1:0]    rd_q;
	logic                pv_s1;
	logic [IDX_W-1:0]    ix_s1;
	logic [CNT_W-1:0]    cnt_q;
	logic                found_q;
	logic [IDX_W-1:0]    m_idx_q;
	logic [7:0]          m_hops_q;
	logic [31:0]         m_ls_q;
	logic                m_saved_q;
	logic                vic_found_q;
	logic [IDX_W-1:0]    vic_idx_q;
	logic [7:0]          best_hops_q;
	logic [31:0]         oldest_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ntwe_pkg::ENTRY_W-1:0] ram_wdata;
	logic [ntwe_pkg::ENTRY_W-1:0] ram_rdata;

	logic [63:0]         e_hi;
	logic [63:0]         e_lo;
	logic [7:0]          e_hops;
	logic [31:0]         e_ls;
	logic                e_valid;
	logic                e_saved;
	logic [31:0]         e_age;
	logic                e_stale;
	logic                free_any;
	logic [IDX_W-1:0]    free_idx;
	logic                too_soon;
	logic                is_add;

	ntwe_ram #(
		.WIDTH(ntwe_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign is_add    = (it_q.mode == ntwe_pkg::MODE_ADD_CONTACT);
	assign too_soon  = ((it_q.now - m_ls_q) < cfg.min_interval);

	always_comb begin
		{e_hi, e_lo, e_hops, e_ls} = ram_rdata;
		e_valid  = valid_q[ix_s1];
		e_saved  = saved_q[ix_s1];
		e_age    = it_q.now - e_ls;
		e_stale  = e_valid && !e_saved && (e_age > cfg.stale_age);
		free_any = !(&valid_q);
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	// result of an item that is answered without a table walk
	always_comb begin
		res_init              = '0;
		res_init.status       = ntwe_pkg::ST_DONE;
		res_init.save_pending = dirty_q;
		if (q_item.kind == ntwe_pkg::KIND_OWN) begin
			res_init.status = ntwe_pkg::ST_OWN;
		end else if (q_item.kind == ntwe_pkg::KIND_RATE) begin
			res_init.status = ntwe_pkg::ST_RATE_LIMITED;
		end else if (q_item.mode == ntwe_pkg::MODE_CLEAR_ALL) begin
			res_init.save_pending = 1'b0;
		end
	end

	// table writes: refresh of a known entry, or fill of a free slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = m_idx_q;
		ram_wdata = {it_q.hash_high, it_q.hash_low, it_q.hops, it_q.now};
		if (state_q == S_DECIDE && it_q.mode == ntwe_pkg::MODE_ANNOUNCE && found_q
			&& !too_soon) begin
			ram_we = 1'b1;
		end else if (state_q == S_INSERT) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx;
			ram_wdata = {it_q.hash_high, it_q.hash_low,
				(is_add ? 8'd0 : it_q.hops), it_q.now};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			dirty_q     <= 1'b0;
			pv_s1       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q        <= q_item;
						res_q       <= res_init;
						rd_q        <= '0;
						pv_s1       <= 1'b0;
						cnt_q       <= '0;
						found_q     <= 1'b0;
						vic_found_q <= 1'b0;
						best_hops_q <= '0;
						oldest_q    <= '1;
						if (q_item.kind != ntwe_pkg::KIND_RUN) begin
							state_q <= S_OUT;
						end else begin
							case (q_item.mode)
								ntwe_pkg::MODE_ANNOUNCE, ntwe_pkg::MODE_ADD_CONTACT,
								ntwe_pkg::MODE_LOOKUP, ntwe_pkg::MODE_COUNT_ONLINE: begin
									state_q <= S_SCAN;
								end
								ntwe_pkg::MODE_CLEAR_UNSAVED: begin
									valid_q <= valid_q & saved_q;
									state_q <= S_OUT;
								end
								ntwe_pkg::MODE_CLEAR_ALL: begin
									valid_q <= '0;
									dirty_q <= 1'b0;
									state_q <= S_OUT;
								end
								default: begin
									state_q <= S_OUT;
								end
							endcase
						end
					end
				end
				S_SCAN: begin
					if (rd_q != CNT_W'(TABLE_DEPTH)) rd_q <= rd_q + 1'b1;
					pv_s1 <= (rd_q != CNT_W'(TABLE_DEPTH));
					ix_s1 <= rd_q[IDX_W-1:0];
					if (pv_s1) begin
						if (e_valid && !found_q && e_hi == it_q.hash_high
							&& e_lo == it_q.hash_low) begin
							found_q   <= 1'b1;
							m_idx_q   <= ix_s1;
							m_hops_q  <= e_hops;
							m_ls_q    <= e_ls;
							m_saved_q <= e_saved;
						end
						if (e_valid && e_age <= it_q.max_age) cnt_q <= cnt_q + 1'b1;
						stale_q[ix_s1] <= e_stale;
						if (e_valid && !e_saved && !e_stale && (e_hops > best_hops_q
							|| (e_hops == best_hops_q && e_ls < oldest_q))) begin
							vic_found_q <= 1'b1;
							vic_idx_q   <= ix_s1;
							best_hops_q <= e_hops;
							oldest_q    <= e_ls;
						end
						if (ix_s1 == IDX_W'(TABLE_DEPTH - 1)) state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (it_q.mode)
						ntwe_pkg::MODE_ANNOUNCE: begin
							if (found_q) begin
								state_q <= S_OUT;
								res_q.slot <= 6'(m_idx_q);
								res_q.entry_is_saved <= m_saved_q;
								if (too_soon) begin
									res_q.status          <= ntwe_pkg::ST_TOO_SOON;
									res_q.entry_hops      <= m_hops_q;
									res_q.entry_last_seen <= m_ls_q;
								end else begin
									res_q.status          <= ntwe_pkg::ST_UPDATED;
									res_q.entry_hops      <= it_q.hops;
									res_q.entry_last_seen <= it_q.now;
									if (m_saved_q) begin
										dirty_q <= 1'b1;
										res_q.save_pending <= 1'b1;
									end
								end
							end else if (free_any) begin
								state_q <= S_INSERT;
							end else if (|stale_q) begin
								valid_q <= valid_q & ~stale_q;
								state_q <= S_INSERT;
							end else if (vic_found_q) begin
								valid_q[vic_idx_q] <= 1'b0;
								state_q <= S_INSERT;
							end else begin
								state_q <= S_OUT;
								res_q.status <= ntwe_pkg::ST_DROPPED_FULL;
							end
						end
						ntwe_pkg::MODE_ADD_CONTACT: begin
							if (found_q) begin
								state_q               <= S_OUT;
								saved_q[m_idx_q]      <= 1'b1;
								res_q.status          <= ntwe_pkg::ST_UPDATED;
								res_q.slot            <= 6'(m_idx_q);
								res_q.entry_hops      <= m_hops_q;
								res_q.entry_last_seen <= m_ls_q;
								res_q.entry_is_saved  <= 1'b1;
							end else if (free_any) begin
								state_q <= S_INSERT;
							end else begin
								state_q <= S_OUT;
								res_q.status <= ntwe_pkg::ST_DROPPED_FULL;
							end
						end
						ntwe_pkg::MODE_LOOKUP: begin
							state_q <= S_OUT;
							if (found_q) begin
								res_q.status          <= ntwe_pkg::ST_FOUND;
								res_q.slot            <= 6'(m_idx_q);
								res_q.entry_hops      <= m_hops_q;
								res_q.entry_last_seen <= m_ls_q;
								res_q.entry_is_saved  <= m_saved_q;
							end else begin
								res_q.status <= ntwe_pkg::ST_NOT_FOUND;
							end
						end
						default: begin
							state_q <= S_OUT;
							res_q.online_count <= 7'(cnt_q);
						end
					endcase
				end
				S_INSERT: begin
					valid_q[free_idx]     <= 1'b1;
					saved_q[free_idx]     <= is_add;
					res_q.status          <= ntwe_pkg::ST_INSERTED;
					res_q.slot            <= 6'(free_idx);
					res_q.entry_hops      <= is_add ? 8'd0 : it_q.hops;
					res_q.entry_last_seen <= it_q.now;
					res_q.entry_is_saved  <= is_add;
					state_q               <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_dirty_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dirty_q) |-> $past(pop && q_item.mode == ntwe_pkg::MODE_CLEAR_ALL))
		else $error("save flag cleared outside clear all");
	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |=> valid_q[$past(free_idx)])
		else $error("inserted slot not marked valid");
	a_stale_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> ((stale_q & ~valid_q) == '0))
		else $error("stale mark on an empty slot");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (cnt_q <= CNT_W'(TABLE_DEPTH)))
		else $error("online count beyond table depth");
`endif

endmodule

// ===== sv/neighbor_table_with_eviction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_with_eviction
// Neighbor table keyed by a 128-bit destination hash, with eviction.
// ----------------------------------------------------------------------------
// Each transfer yields exactly one result. Own-hash and rate-limited
// announces, clears and unused modes go straight to the output; announce, add
// contact, lookup and count online walk the table one slot per cycle through
// the entry RAM's registered read port, then decide, fill a slot if needed
// and output the result. A two-entry queue after the input filter lets
// transfers be taken while the table walk runs.
module neighbor_table_with_eviction #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode, dest_hash_high, dest_hash_low, hop_count, now_ms, max_age_ms
	input  logic [207:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, slot, entry_hops, entry_last_seen, entry_is_saved,
	// online_count, save_pending
	output logic [63:0]  m_tdata
);

	ntwe_pkg::cfg_t    cfg_q;
	ntwe_pkg::item_t   f_item;
	ntwe_pkg::item_t   q_head;
	ntwe_pkg::result_t res;
	logic              f_push;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stale_age    <= 32'd600000;
			cfg_q.min_interval <= 32'd1000;
			cfg_q.rate_limit   <= 8'd10;
			cfg_q.own_high     <= '0;
			cfg_q.own_low      <= '0;
			cfg_q.own_enable   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ntwe_pkg::REG_STALE_AGE:    cfg_q.stale_age    <= cfg_data[31:0];
				ntwe_pkg::REG_MIN_INTERVAL: cfg_q.min_interval <= cfg_data[31:0];
				ntwe_pkg::REG_RATE_LIMIT:   cfg_q.rate_limit   <= cfg_data[7:0];
				ntwe_pkg::REG_OWN_HIGH:     cfg_q.own_high     <= cfg_data;
				ntwe_pkg::REG_OWN_LOW:      cfg_q.own_low      <= cfg_data;
				ntwe_pkg::REG_OWN_ENABLE:   cfg_q.own_enable   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ntwe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(s_tvalid),
		.in_data (s_tdata),
		.full    (q_full),
		.in_ready(s_tready),
		.push    (f_push),
		.item    (f_item)
	);

	ntwe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_item(f_item),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_valid),
		.head     (q_head)
	);

	ntwe_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_head),
		.pop      (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {5'd0, res};

endmodule
